// ===== rtl/dcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Directed cycle detector package
// Shared sizes, item codes and the control bundle of the adjacency store.
// ----------------------------------------------------------------------------
package dcd_pkg;

   localparam int MAX_NODES = 64;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int COUNT_W   = NODE_W + 1;

   localparam logic [COUNT_W-1:0] NODE_LIMIT = COUNT_W'(MAX_NODES);

   // Item codes carried on req_kind.
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_CHECK = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef logic [MAX_NODES-1:0] row_type;
   typedef logic [NODE_W-1:0]    node_type;
   typedef logic [COUNT_W-1:0]   count_type;

   // Control bundle from the walk sequencer to the adjacency store.
   typedef struct packed {
      logic     clear_all;
      logic     rd_en;
      node_type rd_addr;
      logic     wr_en;
      node_type wr_addr;
   } adj_req_type;

   // One saved level of the walk: the node and the next column to scan.
   typedef struct packed {
      count_type pos;
      node_type  node;
   } stack_entry_type;

endpackage
`default_nettype wire

// ===== rtl/directed_cycle_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Directed cycle detector
// Busy: an in-range add keeps busy high for one cycle after its transfer;
// any other add, a clear or the unused kind leaves busy low. A check holds
// busy until its walk ends; the single column scanner tests one adjacency
// bit per cycle while it scans a row, and the check then strobes its
// result in the first cycle with busy low. Throughput: one item at a time.
// Reset empties the matrix and sets the node count to 64; results cannot stall.
// ----------------------------------------------------------------------------
module directed_cycle_detector (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Item channel.
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_kind,
   input  wire logic [dcd_pkg::NODE_W-1:0]   req_src_node,
   input  wire logic [dcd_pkg::NODE_W-1:0]   req_dst_node,
   // Result channel.
   output logic                              rsp_valid,
   output logic                              rsp_has_cycle,
   // Node count register.
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [dcd_pkg::COUNT_W-1:0]  csr_data
);

   // The sequencer walks through these states. ROOT picks the next unvisited
   // start node, SCAN tests one column of the current row per cycle, and
   // RESTORE reloads the parent level from the stack memory after a pop.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_ROOT,
      ST_SCAN,
      ST_RESTORE
   } state_type;

   state_type                  state_ff, state_in;
   dcd_pkg::count_type         node_count_ff;
   dcd_pkg::count_type         active_n;
   dcd_pkg::node_type          src_ff, src_in;
   dcd_pkg::node_type          dst_ff, dst_in;
   dcd_pkg::row_type           visited_ff, visited_in;
   dcd_pkg::row_type           on_path_ff, on_path_in;
   dcd_pkg::count_type         depth_ff, depth_in;
   dcd_pkg::count_type         root_ff, root_in;
   dcd_pkg::node_type          cur_node_ff, cur_node_in;
   dcd_pkg::count_type         cur_pos_ff, cur_pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       has_cycle_ff, has_cycle_in;

   dcd_pkg::adj_req_type       adj_req;
   dcd_pkg::row_type           adj_wr_row;
   dcd_pkg::row_type           adj_row;

   // Stack memory for the saved levels of the walk; the current level lives
   // in cur_node_ff and cur_pos_ff, so the memory holds depth-1 entries.
   dcd_pkg::stack_entry_type   stack_mem [dcd_pkg::MAX_NODES];
   dcd_pkg::stack_entry_type   stack_rd_ff;
   logic                       stk_we;
   dcd_pkg::node_type          stk_waddr;
   dcd_pkg::stack_entry_type   stk_wdata;
   logic                       stk_re;
   dcd_pkg::node_type          stk_raddr;

   dcd_pkg::count_type         depth_dec;
   dcd_pkg::count_type         depth_dec2;
   dcd_pkg::count_type         pos_inc;
   dcd_pkg::node_type          col;

   dcd_adj_store u_adj_store (
      .clock  (clock),
      .reset  (reset),
      .req    (adj_req),
      .wr_row (adj_wr_row),
      .rd_row (adj_row)
   );

   // Node counts above the matrix size behave as the matrix size.
   assign active_n   = (node_count_ff > dcd_pkg::NODE_LIMIT) ? dcd_pkg::NODE_LIMIT
                                                             : node_count_ff;
   assign depth_dec  = depth_ff - dcd_pkg::count_type'(1);
   assign depth_dec2 = depth_ff - dcd_pkg::count_type'(2);
   assign pos_inc    = cur_pos_ff + dcd_pkg::count_type'(1);
   assign col        = cur_pos_ff[dcd_pkg::NODE_W-1:0];

   assign busy          = (state_ff != ST_IDLE);
   assign csr_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_has_cycle = has_cycle_ff;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      visited_in   = visited_ff;
      on_path_in   = on_path_ff;
      depth_in     = depth_ff;
      root_in      = root_ff;
      cur_node_in  = cur_node_ff;
      cur_pos_in   = cur_pos_ff;
      rsp_valid_in = 1'b0;
      has_cycle_in = has_cycle_ff;
      adj_req      = '0;
      adj_wr_row   = adj_row | (dcd_pkg::row_type'(1) << dst_ff);
      stk_we       = 1'b0;
      stk_waddr    = depth_dec[dcd_pkg::NODE_W-1:0];
      stk_wdata    = '{pos: pos_inc, node: cur_node_ff};
      stk_re       = 1'b0;
      stk_raddr    = depth_dec2[dcd_pkg::NODE_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  dcd_pkg::KIND_ADD: begin
                     // Out-of-range endpoints drop the edge; otherwise the
                     // source row is fetched for a read-modify-write.
                     if ({1'b0, req_src_node} < active_n &&
                         {1'b0, req_dst_node} < active_n) begin
                        adj_req.rd_en   = 1'b1;
                        adj_req.rd_addr = req_src_node;
                        src_in          = req_src_node;
                        dst_in          = req_dst_node;
                        state_in        = ST_ADD;
                     end
                  end
                  dcd_pkg::KIND_CHECK: begin
                     visited_in = '0;
                     on_path_in = '0;
                     depth_in   = '0;
                     root_in    = '0;
                     state_in   = ST_ROOT;
                  end
                  dcd_pkg::KIND_CLEAR: begin
                     adj_req.clear_all = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_ADD: begin
            adj_req.wr_en   = 1'b1;
            adj_req.wr_addr = src_ff;
            state_in        = ST_IDLE;
         end

         ST_ROOT: begin
            if (root_ff >= active_n) begin
               // Every root has been walked without meeting the path.
               rsp_valid_in = 1'b1;
               has_cycle_in = 1'b0;
               state_in     = ST_IDLE;
            end else if (visited_ff[root_ff[dcd_pkg::NODE_W-1:0]]) begin
               root_in = root_ff + dcd_pkg::count_type'(1);
            end else begin
               depth_in        = dcd_pkg::count_type'(1);
               cur_node_in     = root_ff[dcd_pkg::NODE_W-1:0];
               cur_pos_in      = '0;
               visited_in[root_ff[dcd_pkg::NODE_W-1:0]] = 1'b1;
               on_path_in[root_ff[dcd_pkg::NODE_W-1:0]] = 1'b1;
               adj_req.rd_en   = 1'b1;
               adj_req.rd_addr = root_ff[dcd_pkg::NODE_W-1:0];
               state_in        = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (cur_pos_ff >= active_n) begin
               // Row exhausted: the node leaves the path.
               on_path_in[cur_node_ff] = 1'b0;
               depth_in                = depth_dec;
               if (depth_ff == dcd_pkg::count_type'(1)) begin
                  root_in  = root_ff + dcd_pkg::count_type'(1);
                  state_in = ST_ROOT;
               end else begin
                  stk_re   = 1'b1;
                  state_in = ST_RESTORE;
               end
            end else if (!adj_row[col]) begin
               cur_pos_in = pos_inc;
            end else begin
               cur_pos_in = pos_inc;
               if (on_path_ff[col]) begin
                  // An edge back onto the current path closes a cycle.
                  rsp_valid_in = 1'b1;
                  has_cycle_in = 1'b1;
                  state_in     = ST_IDLE;
               end else if (!visited_ff[col] && depth_ff < dcd_pkg::NODE_LIMIT) begin
                  // Descend: save this level with its resume column.
                  stk_we          = 1'b1;
                  cur_node_in     = col;
                  cur_pos_in      = '0;
                  depth_in        = depth_ff + dcd_pkg::count_type'(1);
                  visited_in[col] = 1'b1;
                  on_path_in[col] = 1'b1;
                  adj_req.rd_en   = 1'b1;
                  adj_req.rd_addr = col;
               end
            end
         end

         ST_RESTORE: begin
            cur_node_in     = stack_rd_ff.node;
            cur_pos_in      = stack_rd_ff.pos;
            adj_req.rd_en   = 1'b1;
            adj_req.rd_addr = stack_rd_ff.node;
            state_in        = ST_SCAN;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= dcd_pkg::NODE_LIMIT;
         visited_ff    <= '0;
         on_path_ff    <= '0;
         depth_ff      <= '0;
         root_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         has_cycle_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         on_path_ff   <= on_path_in;
         depth_ff     <= depth_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
         has_cycle_ff <= has_cycle_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_data;
         end
      end
   end

   // Walk payload registers carry no reset.
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      cur_node_ff <= cur_node_in;
      cur_pos_ff  <= cur_pos_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stack_rd_ff <= stack_mem[stk_raddr];
      end
   end

   // A result is only ever produced by the root or scan steps of a check.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_ROOT || $past(state_ff) == ST_SCAN))
      else $error("result strobe without a finishing walk step");

   // A result strobe lasts one cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // Every node on the current path has been visited.
   assert property (@(posedge clock) disable iff (reset)
      (on_path_ff & ~visited_ff) == '0)
      else $error("path node missing from the visited set");

   // The scanner always has a current level to work on.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_RESTORE) |-> depth_ff != '0)
      else $error("scan with an empty stack");

   // The stack never grows beyond the matrix size.
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= dcd_pkg::NODE_LIMIT)
      else $error("stack depth overflow");

endmodule
`default_nettype wire

// ===== rtl/dcd_adj_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency store
// One row per source node in a memory, with a valid bit per row so that
// reset and a clear empty the whole matrix by clearing the valid bits alone.
// ----------------------------------------------------------------------------
module dcd_adj_store (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dcd_pkg::adj_req_type req,
   input  wire dcd_pkg::row_type     wr_row,
   output dcd_pkg::row_type          rd_row
);

   dcd_pkg::row_type                    mem [dcd_pkg::MAX_NODES];
   logic [dcd_pkg::MAX_NODES-1:0]       valid_ff;
   dcd_pkg::row_type                    rd_data_ff;
   logic                                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= wr_row;
      end
      if (req.rd_en) begin
         rd_data_ff  <= mem[req.rd_addr];
         rd_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || req.clear_all) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   // A row never written since the last clear reads as empty.
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ===== dv/tb_directed_cycle_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directed cycle detector testbench
// Loads edge lists into the detector, runs cycle checks under several node
// counts and idle patterns, and compares every has_cycle result with a
// depth-first walk over a private copy of the adjacency matrix.
// ----------------------------------------------------------------------------
module tb_directed_cycle_detector;

   // Kind code that the block must treat as a no-operation.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int HALF_PERIOD_NS = 4;
   localparam int RESET_CYCLES   = 7;

   // Worst-case length of one check walk at the full node count, plus a
   // little slack for the result strobe.
   localparam int unsigned WALK_CYCLES = dcd_pkg::MAX_NODES * (dcd_pkg::MAX_NODES + 3) + 8;

   // Watchdog: every planned item taken as a full-size check, each preceded
   // by a long sender gap, and then the whole lot taken four times over.
   localparam int unsigned CYCLE_LIMIT = 4 * 1300 * (WALK_CYCLES + 64);

   // Items planned in each random phase.
   localparam int unsigned PHASE_ITEMS = 90;

   typedef struct {
      logic [1:0]        kind;
      dcd_pkg::node_type src;
      dcd_pkg::node_type dst;
      bit                drain;   // hold this transfer back until no result is due
   } graph_op_type;

   // ------------------------------------------------------------------------
   // Ports of the block. The item inputs are known from time zero.
   // ------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_kind = dcd_pkg::KIND_ADD;
   dcd_pkg::node_type  req_src_node = '0;
   dcd_pkg::node_type  req_dst_node = '0;
   logic               rsp_valid;
   logic               rsp_has_cycle;
   logic               csr_valid;
   logic               csr_ready;
   dcd_pkg::count_type csr_data;

   directed_cycle_detector dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_src_node  (req_src_node),
      .req_dst_node  (req_dst_node),
      .rsp_valid     (rsp_valid),
      .rsp_has_cycle (rsp_has_cycle),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   // ------------------------------------------------------------------------
   // Testbench state.
   // ------------------------------------------------------------------------
   graph_op_type op_queue [$];          // items waiting for the driver
   bit           has_cycle_expected [$]; // predicted results, oldest first

   // Private copy of the block's graph and its node count register; both
   // follow the block's reset in the monitor.
   dcd_pkg::row_type   edge_matrix [dcd_pkg::MAX_NODES];
   dcd_pkg::count_type node_count_q;

   // Handshake flags captured at the rising edge and read at the falling one.
   logic        req_fire = 1'b0;
   logic        csr_fire = 1'b0;

   int unsigned idle_pct;
   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned items_accepted;
   int unsigned checks_run;
   int unsigned cycles_found;
   int unsigned settings_written;

   // The clock simply toggles every half period from time zero.
   initial clock = 1'b0;
   always #(HALF_PERIOD_NS) clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor.
   // ------------------------------------------------------------------------

   // Number of vertices the walk may touch: the block clamps its count at the
   // size of the matrix, so a setting above it behaves as the full size.
   function automatic int unsigned live_nodes();
      return (node_count_q > dcd_pkg::NODE_LIMIT) ? dcd_pkg::MAX_NODES
                                                  : int'(node_count_q);
   endfunction

   // Iterative depth-first walk, roots in ascending order. Each stack level
   // keeps its own scan column so that a node resumes where it left off
   // after a child is popped. The walk stops at the first edge that lands on
   // a node still on the current path.
   function automatic bit walk_finds_cycle(input int unsigned n);
      dcd_pkg::row_type seen;
      dcd_pkg::row_type on_path;
      int unsigned path_node [dcd_pkg::MAX_NODES];
      int unsigned next_col [dcd_pkg::MAX_NODES];
      int unsigned depth;
      int unsigned u;
      int unsigned j;
      seen    = '0;
      on_path = '0;
      depth   = 0;
      for (int unsigned root = 0; root < n; root++) begin
         if (!seen[root]) begin
            seen[root]    = 1'b1;
            on_path[root] = 1'b1;
            path_node[0]  = root;
            next_col[0]   = 0;
            depth         = 1;
            while (depth > 0) begin
               u = path_node[depth-1];
               j = next_col[depth-1];
               while (j < n && !edge_matrix[u][j])
                  j++;
               if (j >= n) begin
                  // Every successor of u is finished, so u leaves the path.
                  on_path[u] = 1'b0;
                  depth--;
               end else begin
                  next_col[depth-1] = j + 1;
                  if (on_path[j])
                     return 1'b1;
                  if (!seen[j] && depth < dcd_pkg::MAX_NODES) begin
                     seen[j]          = 1'b1;
                     on_path[j]       = 1'b1;
                     path_node[depth] = j;
                     next_col[depth]  = 0;
                     depth++;
                  end
               end
            end
         end
      end
      return 1'b0;
   endfunction

   // Applies one accepted item to the private graph and queues the result
   // that a check must give.
   function automatic void apply_graph_op(input logic [1:0] kind,
                                          input dcd_pkg::node_type src,
                                          input dcd_pkg::node_type dst);
      int unsigned n;
      bit          found;
      n = live_nodes();
      case (kind)
         dcd_pkg::KIND_ADD: begin
            // An endpoint outside the live range means the edge is dropped.
            if (src < n && dst < n)
               edge_matrix[src][dst] = 1'b1;
         end
         dcd_pkg::KIND_CHECK: begin
            found = walk_finds_cycle(n);
            has_cycle_expected = {has_cycle_expected, found};
            checks_run++;
            if (found)
               cycles_found++;
         end
         dcd_pkg::KIND_CLEAR: begin
            foreach (edge_matrix[i])
               edge_matrix[i] = '0;
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Driver: presents queued items at the falling edge. The start strobe is
   // assigned once per step, so a run of back-to-back transfers keeps it high
   // without a glitch. A random draw against idle_pct inserts sender gaps.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_items
      graph_op_type next_op;
      logic         present;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_fire) begin
         present = 1'b0;
         if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct &&
             !(op_queue[0].drain && has_cycle_expected.size() != 0)) begin
            next_op = op_queue.pop_front();
            req_kind     <= next_op.kind;
            req_src_node <= next_op.src;
            req_dst_node <= next_op.dst;
            present = 1'b1;
         end
         start <= present;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. Results are checked
   // before the item of the same edge is predicted; with one item in flight
   // at a time the two cannot belong together anyway.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      bit expected_bit;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end else begin
         req_fire <= !reset && start && !busy;
         csr_fire <= !reset && csr_valid && csr_ready;
         if (reset) begin
            node_count_q = dcd_pkg::NODE_LIMIT;
            foreach (edge_matrix[i])
               edge_matrix[i] = '0;
         end else begin
            if (rsp_valid) begin
               if (has_cycle_expected.size() == 0) begin
                  $error("has_cycle: no result expected, actual %0b", rsp_has_cycle);
                  fail_count++;
               end else begin
                  expected_bit = has_cycle_expected.pop_front();
                  if (rsp_has_cycle !== expected_bit) begin
                     $error("has_cycle: expected %0b, actual %0b",
                            expected_bit, rsp_has_cycle);
                     fail_count++;
                  end
               end
            end
            if (csr_valid && csr_ready)
               node_count_q = csr_data;
            if (start && !busy) begin
               items_accepted++;
               apply_graph_op(req_kind, req_src_node, req_dst_node);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic void queue_op(input logic [1:0] kind, input dcd_pkg::node_type src,
                                    input dcd_pkg::node_type dst, input bit drain);
      graph_op_type op;
      op.kind  = kind;
      op.src   = src;
      op.dst   = dst;
      op.drain = drain;
      op_queue = {op_queue, op};
   endfunction

   function automatic dcd_pkg::node_type any_node();
      return dcd_pkg::node_type'($urandom);
   endfunction

   // Waits until every queued item has been transferred, every result has
   // arrived and the block has dropped busy, so that the register may be
   // written safely. An add keeps busy for a cycle after its transfer, hence
   // the short pause before busy is looked at.
   task automatic wait_until_quiet();
      wait (op_queue.size() == 0 && !start);
      wait (has_cycle_expected.size() == 0);
      repeat (4) @(negedge clock);
      while (busy)
         @(negedge clock);
   endtask

   // One transfer on the register channel; csr_fire tells the falling edge
   // whether the rising edge before it took the write.
   task automatic write_node_count(input dcd_pkg::count_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(negedge clock);
      while (!csr_fire);
      csr_valid <= 1'b0;
      csr_data  <= dcd_pkg::count_type'($urandom);
      settings_written++;
   endtask

   // A well-formed round: usually clear, then a burst of forward edges that
   // on their own form no loop while n is above one, then a check. Half of
   // the rounds close a loop on purpose, either by reversing the last edge
   // or by adding one edge at random. Stray items are mixed in: adds with
   // endpoints anywhere in the field range, the unused kind, and extra checks.
   task automatic plan_graph_round(input int unsigned n, inout int unsigned planned);
      int unsigned edge_total;
      int unsigned a;
      int unsigned b;
      bit          closes_loop;
      closes_loop = $urandom_range(1);
      a = 0;
      b = 0;
      if ($urandom_range(99) < 80) begin
         queue_op(dcd_pkg::KIND_CLEAR, any_node(), any_node(), 1'b0);
         planned++;
      end
      edge_total = $urandom_range((2 * n < 48) ? 2 * n : 48, 1);
      for (int unsigned k = 0; k < edge_total; k++) begin
         if (n > 1) begin
            a = $urandom_range(n - 2);
            b = $urandom_range(n - 1, a + 1);
         end
         queue_op(dcd_pkg::KIND_ADD, dcd_pkg::node_type'(a), dcd_pkg::node_type'(b), 1'b0);
         planned++;
         if ($urandom_range(99) < 10)
            queue_op(dcd_pkg::KIND_ADD, any_node(), any_node(), 1'b0);
         if ($urandom_range(99) < 5)
            queue_op(KIND_UNUSED, any_node(), any_node(), 1'b0);
      end
      if (closes_loop) begin
         if ($urandom_range(1))
            queue_op(dcd_pkg::KIND_ADD, dcd_pkg::node_type'(b), dcd_pkg::node_type'(a),
                     1'b0);
         else
            queue_op(dcd_pkg::KIND_ADD, dcd_pkg::node_type'($urandom_range(n - 1)),
                     dcd_pkg::node_type'($urandom_range(n - 1)), 1'b0);
         planned++;
      end
      queue_op(dcd_pkg::KIND_CHECK, any_node(), any_node(), $urandom_range(99) < 4);
      planned++;
      if ($urandom_range(99) < 10) begin
         queue_op(dcd_pkg::KIND_CHECK, any_node(), any_node(), 1'b0);
         planned++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin : run_test
      dcd_pkg::count_type phase_counts [10];
      int unsigned        phase_idle [4];
      int unsigned        planned;
      int unsigned        n;

      // Reset is held at the start of the run and never raised again.
      reset        = 1'b1;
      csr_valid    = 1'b0;
      csr_data     = '0;
      idle_pct     = 0;

      // Node counts for the random phases: the smallest graphs, a spread of
      // small ones, the full matrix, a setting above the matrix size and one
      // mid-sized value drawn at random.
      phase_counts = '{7'd1, 7'd2, 7'd5, 7'd8, 7'd12, 7'd16, 7'd64, 7'd127, 7'd3, 7'd0};
      phase_counts[9] = dcd_pkg::count_type'($urandom_range(63, 17));
      // Sender idle percentages, cycled over the phases.
      phase_idle = '{0, 59, 0, 30};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the full node count: empty graph, the extreme
      // vertex numbers forming a loop, a self loop, a repeated edge and a
      // chain that is closed only by its last edge. The check after the
      // extreme loop holds off until nothing is outstanding.
      write_node_count(dcd_pkg::NODE_LIMIT);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd0, 6'd63, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd63, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_CHECK, 6'd63, 6'd63, 1'b1);
      queue_op(dcd_pkg::KIND_CLEAR, 6'd63, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd63, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd5, 6'd5, 1'b0);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_CLEAR, 6'd0, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd1, 6'd2, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd1, 6'd2, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd2, 6'd3, 1'b0);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd3, 6'd1, 1'b0);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd0, 1'b0);
      queue_op(KIND_UNUSED, 6'd63, 6'd63, 1'b0);
      queue_op(dcd_pkg::KIND_CLEAR, 6'd0, 6'd0, 1'b0);
      // Left loaded on purpose for the lowered count below.
      queue_op(dcd_pkg::KIND_ADD, 6'd40, 6'd50, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd50, 6'd40, 1'b0);

      // With the count lowered, the loop above lies outside the live range
      // and must be ignored; edges reaching past the range are dropped.
      wait_until_quiet();
      write_node_count(7'd8);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd3, 6'd9, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd9, 6'd3, 1'b0);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd7, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_ADD, 6'd0, 6'd7, 1'b0);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd0, 1'b0);

      // A count of zero leaves an empty graph whatever is loaded.
      wait_until_quiet();
      write_node_count(7'd0);
      queue_op(dcd_pkg::KIND_ADD, 6'd0, 6'd0, 1'b0);
      queue_op(dcd_pkg::KIND_CHECK, 6'd0, 6'd0, 1'b0);

      // Random phases. Each starts from a quiet block, sets a new count and
      // idle rate, and then plans rounds until enough items are queued.
      for (int unsigned p = 0; p < 10; p++) begin
         wait_until_quiet();
         write_node_count(phase_counts[p]);
         idle_pct = phase_idle[p % 4];
         n = (phase_counts[p] > dcd_pkg::NODE_LIMIT) ? dcd_pkg::MAX_NODES
                                                     : int'(phase_counts[p]);
         planned = 0;
         while (planned < PHASE_ITEMS)
            plan_graph_round(n, planned);
      end

      // Let the last walk finish and leave room for any stray strobe.
      wait_until_quiet();
      repeat (WALK_CYCLES) @(negedge clock);

      if (has_cycle_expected.size() != 0) begin
         $error("has_cycle: %0d expected results never arrived", has_cycle_expected.size());
         fail_count++;
      end

      $display("Transferred %0d items under %0d node-count settings.",
               items_accepted, settings_written);
      $display("Ran %0d cycle checks, %0d of which were expected to find a cycle.",
               checks_run, cycles_found);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
